// ===== hdl/roi_tm_pkg.sv =====
// ----------------------------------------------------------------------------
// ROI template match package
// Widths, reset values, register indexes and small helpers shared by the
// interfaces and the matcher core.
// ----------------------------------------------------------------------------
package roi_tm_pkg;

   localparam int unsigned WINDOW_WIDTH_DEF   = 116;
   localparam int unsigned WINDOW_HEIGHT_DEF  = 26;
   localparam int unsigned TEMPLATE_COUNT_DEF = 3;

   localparam int unsigned COORD_W     = 12;
   localparam int unsigned COLOR_W     = 8;
   localparam int unsigned SEL_W       = 2;
   localparam int unsigned THR_W       = 9;
   localparam int unsigned RUN_W       = 16;
   localparam int unsigned TOTAL_W     = 32;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [COORD_W-1:0] WINDOW_COLUMN_RST   = 12'd98;
   localparam logic [COORD_W-1:0] WINDOW_ROW_RST      = 12'd975;
   localparam logic [THR_W-1:0]   MATCH_THRESHOLD_RST = 9'd100;
   localparam logic [RUN_W-1:0]   PERSIST_FRAMES_RST  = 16'd60;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW_COLUMN   = 2'd0,
      CSR_WINDOW_ROW      = 2'd1,
      CSR_MATCH_THRESHOLD = 2'd2,
      CSR_PERSIST_FRAMES  = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_TEMPLATE_WRITE = 1'b0,
      OP_VIDEO_PIXEL    = 1'b1
   } opcode_type;

   function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                   input logic [COLOR_W-1:0] b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

// ===== hdl/roi_tm_if.sv =====
// ----------------------------------------------------------------------------
// ROI template match stream interfaces
// Valid/ready channels for pixel transactions in and frame results out.
// ----------------------------------------------------------------------------
interface roi_tm_req_if;
   logic                              valid;
   logic                              ready;
   logic                              opcode;
   logic [roi_tm_pkg::SEL_W-1:0]      template_select;
   logic [roi_tm_pkg::COORD_W-1:0]    column;
   logic [roi_tm_pkg::COORD_W-1:0]    row;
   logic [roi_tm_pkg::COLOR_W-1:0]    blue;
   logic [roi_tm_pkg::COLOR_W-1:0]    green;
   logic [roi_tm_pkg::COLOR_W-1:0]    red;
   logic                              frame_end;

   modport source (
      output valid, opcode, template_select, column, row, blue, green, red, frame_end,
      input  ready
   );
   modport sink (
      input  valid, opcode, template_select, column, row, blue, green, red, frame_end,
      output ready
   );
endinterface

interface roi_tm_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              frame_matched;
   logic [roi_tm_pkg::RUN_W-1:0]      run_frames;
   logic [roi_tm_pkg::TOTAL_W-1:0]    counted_total;

   modport source (
      output valid, frame_matched, run_frames, counted_total,
      input  ready
   );
   modport sink (
      input  valid, frame_matched, run_frames, counted_total,
      output ready
   );
endinterface

// ===== hdl/roi_template_match_persistence_core.sv =====
// ----------------------------------------------------------------------------
// ROI template match with persistence
// Compares a crop window of each frame against stored colour templates and
// qualifies matched frames with a persistence run counter.
// ----------------------------------------------------------------------------
//  channel   direction  transaction
//  req_bus   in         template pixel write or video pixel (valid/ready)
//  rsp_bus   out        frame result on the last video pixel of a frame
//  csr_*     in         register write, no wait, no read-back
//
//  One transaction per cycle, barring stalls. A result is registered after the
//  frame-ending pixel is accepted: template read at the accepting edge,
//  difference/threshold, then run/total update into the output register.
//  Template writes and window reads share one memory port each cycle.
//  Synchronous reset clears control, run and total; template memory is left.
//  req_bus.ready drops only when a result is due while the output register
//  still holds an untaken result.
// ----------------------------------------------------------------------------
module roi_template_match_persistence_core #(
   parameter int unsigned WINDOW_WIDTH   = roi_tm_pkg::WINDOW_WIDTH_DEF,
   parameter int unsigned WINDOW_HEIGHT  = roi_tm_pkg::WINDOW_HEIGHT_DEF,
   parameter int unsigned TEMPLATE_COUNT = roi_tm_pkg::TEMPLATE_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   roi_tm_req_if.sink                          req_bus,
   roi_tm_rsp_if.source                        rsp_bus,
   input  logic                                csr_write,
   input  logic [roi_tm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [roi_tm_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int unsigned COORD_W = roi_tm_pkg::COORD_W;
   localparam int unsigned COLOR_W = roi_tm_pkg::COLOR_W;
   localparam int unsigned THR_W   = roi_tm_pkg::THR_W;
   localparam int unsigned RUN_W   = roi_tm_pkg::RUN_W;
   localparam int unsigned TOTAL_W = roi_tm_pkg::TOTAL_W;
   localparam int unsigned DEPTH   = WINDOW_WIDTH * WINDOW_HEIGHT;
   localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned LANE_W  = 3 * COLOR_W;
   localparam int unsigned MEM_W   = TEMPLATE_COUNT * LANE_W;

   // configuration registers
   logic [COORD_W-1:0] window_column_ff;
   logic [COORD_W-1:0] window_row_ff;
   logic [THR_W-1:0]   match_threshold_ff;
   logic [RUN_W-1:0]   persist_frames_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_column_ff   <= roi_tm_pkg::WINDOW_COLUMN_RST;
         window_row_ff      <= roi_tm_pkg::WINDOW_ROW_RST;
         match_threshold_ff <= roi_tm_pkg::MATCH_THRESHOLD_RST;
         persist_frames_ff  <= roi_tm_pkg::PERSIST_FRAMES_RST;
      end else if (csr_write) begin
         case (roi_tm_pkg::csr_index_type'(csr_index))
            roi_tm_pkg::CSR_WINDOW_COLUMN: begin
               window_column_ff <= csr_data[COORD_W-1:0];
            end
            roi_tm_pkg::CSR_WINDOW_ROW: begin
               window_row_ff <= csr_data[COORD_W-1:0];
            end
            roi_tm_pkg::CSR_MATCH_THRESHOLD: begin
               match_threshold_ff <= csr_data[THR_W-1:0];
            end
            roi_tm_pkg::CSR_PERSIST_FRAMES: begin
               persist_frames_ff <= csr_data[RUN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- stage 0
   logic               advance;
   logic               stall;
   logic               accept;
   logic               is_video;
   logic [COORD_W-1:0] dc;
   logic [COORD_W-1:0] dr;
   logic               in_window;
   logic               write_ok;
   logic [COORD_W-1:0] rel_col;
   logic [COORD_W-1:0] rel_row;
   logic [31:0]        addr_sum;
   logic [AW-1:0]      mem_addr;

   assign advance       = !stall;
   assign req_bus.ready = advance;
   assign accept        = req_bus.valid && advance;
   assign is_video      = (req_bus.opcode == roi_tm_pkg::OP_VIDEO_PIXEL);

   assign dc = req_bus.column - window_column_ff;
   assign dr = req_bus.row - window_row_ff;
   assign in_window = (req_bus.column >= window_column_ff) && (req_bus.row >= window_row_ff)
                      && (32'(dc) < WINDOW_WIDTH) && (32'(dr) < WINDOW_HEIGHT);
   assign write_ok  = (32'(req_bus.template_select) < TEMPLATE_COUNT)
                      && (32'(req_bus.column) < WINDOW_WIDTH)
                      && (32'(req_bus.row) < WINDOW_HEIGHT);

   assign rel_col  = is_video ? dc : req_bus.column;
   assign rel_row  = is_video ? dr : req_bus.row;
   assign addr_sum = 32'(rel_row) * WINDOW_WIDTH + 32'(rel_col);
   assign mem_addr = addr_sum[AW-1:0];

   // template memory: one lane per template, all lanes read together
   logic [MEM_W-1:0] template_mem [DEPTH];
   logic [MEM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (accept && !is_video && write_ok) begin
         for (int t = 0; t < TEMPLATE_COUNT; t++) begin
            if (32'(req_bus.template_select) == t) begin
               template_mem[mem_addr][t*LANE_W +: LANE_W] <=
                  {req_bus.blue, req_bus.green, req_bus.red};
            end
         end
      end
      if (accept && is_video && in_window) begin
         rd_data_ff <= template_mem[mem_addr];
      end
   end

   // ---------------------------------------------------------------- stage 1
   logic               s1_valid_ff;
   logic               s1_hit_ff;
   logic               s1_fend_ff;
   logic [COLOR_W-1:0] s1_blue_ff;
   logic [COLOR_W-1:0] s1_green_ff;
   logic [COLOR_W-1:0] s1_red_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept && is_video;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_hit_ff   <= in_window;
         s1_fend_ff  <= req_bus.frame_end;
         s1_blue_ff  <= req_bus.blue;
         s1_green_ff <= req_bus.green;
         s1_red_ff   <= req_bus.red;
      end
   end

   logic [TEMPLATE_COUNT-1:0][COLOR_W-1:0] worst_ff;
   logic [TEMPLATE_COUNT-1:0][COLOR_W-1:0] worst_in;
   logic [TEMPLATE_COUNT-1:0]              below;
   logic                                   frame_hit;

   always_comb begin
      logic [LANE_W-1:0]  px;
      logic [COLOR_W-1:0] m;
      logic [COLOR_W-1:0] d;
      for (int t = 0; t < TEMPLATE_COUNT; t++) begin
         px = rd_data_ff[t*LANE_W +: LANE_W];
         m  = roi_tm_pkg::abs_diff(s1_blue_ff, px[3*COLOR_W-1:2*COLOR_W]);
         d  = roi_tm_pkg::abs_diff(s1_green_ff, px[2*COLOR_W-1:COLOR_W]);
         if (d > m) m = d;
         d  = roi_tm_pkg::abs_diff(s1_red_ff, px[COLOR_W-1:0]);
         if (d > m) m = d;
         worst_in[t] = (s1_hit_ff && (m > worst_ff[t])) ? m : worst_ff[t];
         below[t]    = ({1'b0, worst_in[t]} < match_threshold_ff);
      end
   end

   assign frame_hit = |below;

   always_ff @(posedge clock) begin
      if (reset) begin
         worst_ff <= '0;
      end else if (advance && s1_valid_ff) begin
         worst_ff <= s1_fend_ff ? '0 : worst_in;
      end
   end

   // ---------------------------------------------------------------- stage 2
   logic s2_valid_ff;
   logic s2_matched_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff && s1_fend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_matched_ff <= frame_hit;
      end
   end

   logic [RUN_W-1:0]   run_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic               rsp_valid_ff;
   logic               rsp_matched_ff;
   logic [RUN_W-1:0]   rsp_run_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;

   logic               fire;
   logic               run_sat;
   logic [RUN_W-1:0]   run_inc;
   logic [RUN_W-1:0]   add_amt;
   logic [TOTAL_W:0]   total_sum;
   logic [RUN_W-1:0]   run_in;
   logic [TOTAL_W-1:0] total_in;

   assign stall   = s2_valid_ff && rsp_valid_ff && !rsp_bus.ready;
   assign fire    = s2_valid_ff && advance;
   assign run_sat = &run_ff;
   assign run_inc = run_ff + 1'b1;

   always_comb begin
      if (run_sat) begin
         add_amt = RUN_W'(1);
      end else if (run_inc == persist_frames_ff) begin
         add_amt = persist_frames_ff;
      end else if (run_inc > persist_frames_ff) begin
         add_amt = RUN_W'(1);
      end else begin
         add_amt = '0;
      end
   end

   assign total_sum = {1'b0, total_ff} + (TOTAL_W+1)'(add_amt);

   always_comb begin
      if (!s2_matched_ff) begin
         run_in   = '0;
         total_in = total_ff;
      end else begin
         run_in   = run_sat ? run_ff : run_inc;
         total_in = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         run_ff       <= run_in;
         total_ff     <= total_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_matched_ff <= s2_matched_ff;
         rsp_run_ff     <= run_in;
         rsp_total_ff   <= total_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.frame_matched = rsp_matched_ff;
   assign rsp_bus.run_frames    = rsp_run_ff;
   assign rsp_bus.counted_total = rsp_total_ff;

   // ------------------------------------------------------------- assertions
   a_worst_cleared: assert property (@(posedge clock) disable iff (reset)
      advance && s1_valid_ff && s1_fend_ff |=> worst_ff == '0)
      else $error("worst differences not cleared after frame end");

   a_miss_clears_run: assert property (@(posedge clock) disable iff (reset)
      fire && !s2_matched_ff |=> run_ff == '0 && rsp_run_ff == '0)
      else $error("missed frame did not clear the run");

   a_run_saturates: assert property (@(posedge clock) disable iff (reset)
      fire && s2_matched_ff && run_sat |=> run_sat)
      else $error("run counter left saturation");

   a_total_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> total_ff >= $past(total_ff))
      else $error("qualified total decreased");

endmodule

// ===== dv/tb_roi_template_match_persistence_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ROI template match with persistence - testbench
// Loads a set of template positions in all three templates, then drives
// template writes and video frames through the pixel channel under random
// gaps and stalls. A scoreboard model of the window compare and the run/total
// counters predicts every frame result. Results are checked field by field,
// in order.
// ----------------------------------------------------------------------------
module tb_roi_template_match_persistence_core;

   localparam int unsigned SEL_W       = roi_tm_pkg::SEL_W;
   localparam int unsigned COORD_W     = roi_tm_pkg::COORD_W;
   localparam int unsigned COLOR_W     = roi_tm_pkg::COLOR_W;
   localparam int unsigned RUN_W       = roi_tm_pkg::RUN_W;
   localparam int unsigned TOTAL_W     = roi_tm_pkg::TOTAL_W;
   localparam int unsigned CSR_INDEX_W = roi_tm_pkg::CSR_INDEX_W;
   localparam int unsigned CSR_DATA_W  = roi_tm_pkg::CSR_DATA_W;

   localparam int WIN_W           = int'(roi_tm_pkg::WINDOW_WIDTH_DEF);
   localparam int WIN_H           = int'(roi_tm_pkg::WINDOW_HEIGHT_DEF);
   localparam int TEMPLATES       = int'(roi_tm_pkg::TEMPLATE_COUNT_DEF);
   localparam int STORE_DEPTH     = TEMPLATES * WIN_W * WIN_H;
   localparam int COORD_MAX       = 4095;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 8;
   localparam int LOAD_POINTS     = 16;
   localparam int RANDOM_ITEMS    = 150;

   typedef struct {
      roi_tm_pkg::opcode_type opcode;
      logic [SEL_W-1:0]       template_select;
      logic [COORD_W-1:0]     column;
      logic [COORD_W-1:0]     row;
      logic [COLOR_W-1:0]     blue;
      logic [COLOR_W-1:0]     green;
      logic [COLOR_W-1:0]     red;
      logic                   frame_end;
   } pixel_txn_type;

   typedef struct {
      logic                 frame_matched;
      logic [RUN_W-1:0]     run_frames;
      logic [TOTAL_W-1:0]   counted_total;
   } frame_result_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   roi_tm_req_if req_bus ();
   roi_tm_rsp_if rsp_bus ();

   roi_template_match_persistence_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // scoreboard model state
   logic [23:0]        tmpl_mem [STORE_DEPTH];
   bit                 tmpl_written [STORE_DEPTH] = '{default: 1'b0};
   int                 load_dc [$];
   int                 load_dr [$];
   logic [COLOR_W-1:0] worst_gap [TEMPLATES] = '{default: '0};
   logic [RUN_W-1:0]   run_len    = '0;
   logic [TOTAL_W-1:0] qual_total = '0;
   int cfg_col     = int'(roi_tm_pkg::WINDOW_COLUMN_RST);
   int cfg_row     = int'(roi_tm_pkg::WINDOW_ROW_RST);
   int cfg_thr     = int'(roi_tm_pkg::MATCH_THRESHOLD_RST);
   int cfg_persist = int'(roi_tm_pkg::PERSIST_FRAMES_RST);
   frame_result_type pending_results [$];

   bit sender_gaps_on   = 1'b1;
   bit sink_stalls_on   = 1'b1;
   bit hold_off_request = 1'b0;
   int mismatch_count   = 0;
   int live_items       = 0;
   int quiet_cycles     = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [COLOR_W-1:0] colour_gap(input logic [COLOR_W-1:0] a,
                                                     input logic [COLOR_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                  input logic [TOTAL_W-1:0] b);
      logic [TOTAL_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TOTAL_W] ? '1 : s[TOTAL_W-1:0];
   endfunction

   function automatic logic [COLOR_W-1:0] jitter(input logic [COLOR_W-1:0] base,
                                                 input int spread);
      int v;
      v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return COLOR_W'(v);
   endfunction

   // false when the pixel would compare against a template entry never written
   function automatic bit readable(input int col, input int row);
      int base;
      if (col < cfg_col || row < cfg_row || col - cfg_col >= WIN_W || row - cfg_row >= WIN_H)
         return 1'b1;
      base = (row - cfg_row) * WIN_W + (col - cfg_col);
      for (int t = 0; t < TEMPLATES; t++)
         if (!tmpl_written[t * WIN_W * WIN_H + base]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic pixel_txn_type video_px(input int col, input int row,
                                              input logic [7:0] b, input logic [7:0] g,
                                              input logic [7:0] r, input logic fe);
      pixel_txn_type p;
      p.opcode          = roi_tm_pkg::OP_VIDEO_PIXEL;
      p.template_select = SEL_W'($urandom);
      p.column          = COORD_W'(col);
      p.row             = COORD_W'(row);
      p.blue            = b;
      p.green           = g;
      p.red             = r;
      p.frame_end       = fe;
      return p;
   endfunction

   function automatic pixel_txn_type tmpl_wr(input int sel, input int col, input int row,
                                             input logic [7:0] b, input logic [7:0] g,
                                             input logic [7:0] r, input logic fe);
      pixel_txn_type p;
      p                 = video_px(col, row, b, g, r, fe);
      p.opcode          = roi_tm_pkg::OP_TEMPLATE_WRITE;
      p.template_select = SEL_W'(sel);
      return p;
   endfunction

   // video pixel on a loaded window position, colours close to one template
   function automatic pixel_txn_type window_px(input int tmpl, input int spread,
                                               input logic fe);
      int          dc_max;
      int          dr_max;
      int          picks [$];
      int          k;
      logic [23:0] px;
      dc_max = WIN_W - 1;
      dr_max = WIN_H - 1;
      if (COORD_MAX - cfg_col < dc_max) dc_max = COORD_MAX - cfg_col;
      if (COORD_MAX - cfg_row < dr_max) dr_max = COORD_MAX - cfg_row;
      foreach (load_dc[i])
         if (load_dc[i] <= dc_max && load_dr[i] <= dr_max) picks.push_back(i);
      k  = picks[$urandom_range(0, picks.size() - 1)];
      px = tmpl_mem[tmpl * WIN_W * WIN_H + load_dr[k] * WIN_W + load_dc[k]];
      return video_px(cfg_col + load_dc[k], cfg_row + load_dr[k], jitter(px[23:16], spread),
                      jitter(px[15:8], spread), jitter(px[7:0], spread), fe);
   endfunction

   task automatic predict_pixel(input pixel_txn_type p);
      int                 c;
      int                 r;
      int                 base;
      logic [23:0]        px;
      logic [COLOR_W-1:0] m;
      logic               hit;
      frame_result_type   e;
      c = int'(p.column);
      r = int'(p.row);
      if (p.opcode == roi_tm_pkg::OP_TEMPLATE_WRITE) begin
         if (int'(p.template_select) < TEMPLATES && c < WIN_W && r < WIN_H) begin
            base = int'(p.template_select) * WIN_W * WIN_H + r * WIN_W + c;
            tmpl_mem[base]     = {p.blue, p.green, p.red};
            tmpl_written[base] = 1'b1;
            live_items++;
         end
         return;
      end
      live_items++;
      if (c >= cfg_col && r >= cfg_row && c - cfg_col < WIN_W && r - cfg_row < WIN_H) begin
         base = (r - cfg_row) * WIN_W + (c - cfg_col);
         for (int t = 0; t < TEMPLATES; t++) begin
            px = tmpl_mem[t * WIN_W * WIN_H + base];
            m  = colour_gap(p.blue, px[23:16]);
            if (colour_gap(p.green, px[15:8]) > m) m = colour_gap(p.green, px[15:8]);
            if (colour_gap(p.red, px[7:0]) > m) m = colour_gap(p.red, px[7:0]);
            if (m > worst_gap[t]) worst_gap[t] = m;
         end
      end
      if (!p.frame_end) return;
      hit = 1'b0;
      for (int t = 0; t < TEMPLATES; t++) begin
         if (int'(worst_gap[t]) < cfg_thr) hit = 1'b1;
         worst_gap[t] = '0;
      end
      if (hit) begin
         if (run_len == '1) begin
            qual_total = sat_add(qual_total, TOTAL_W'(1));
         end else begin
            run_len++;
            if (int'(run_len) == cfg_persist)
               qual_total = sat_add(qual_total, TOTAL_W'(cfg_persist));
            else if (int'(run_len) > cfg_persist)
               qual_total = sat_add(qual_total, TOTAL_W'(1));
         end
      end else begin
         run_len = '0;
      end
      e.frame_matched = hit;
      e.run_frames    = run_len;
      e.counted_total = qual_total;
      pending_results.push_back(e);
   endtask

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      mismatch_count++;
      $display("%0t ns: %s got %0h want %0h", $time, what, got, want);
   endtask

   task automatic check_frame_result();
      frame_result_type want;
      if (pending_results.size() == 0) begin
         flag_mismatch("frame result with none pending", rsp_bus.counted_total, 0);
         return;
      end
      want = pending_results.pop_front();
      if (rsp_bus.frame_matched !== want.frame_matched)
         flag_mismatch("frame_matched", rsp_bus.frame_matched, want.frame_matched);
      if (rsp_bus.run_frames !== want.run_frames)
         flag_mismatch("run_frames", rsp_bus.run_frames, want.run_frames);
      if (rsp_bus.counted_total !== want.counted_total)
         flag_mismatch("counted_total", rsp_bus.counted_total, want.counted_total);
   endtask

   // result side: checks, random stalls and the long hold-off
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) check_frame_result();
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall_left       = HOLD_OFF_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          csr_write)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   // valid is left high on return; the next call or configure() decides
   task automatic send_pixel(input pixel_txn_type p);
      int gap;
      if (sender_gaps_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 12);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.opcode          <= p.opcode;
      req_bus.template_select <= p.template_select;
      req_bus.column          <= p.column;
      req_bus.row             <= p.row;
      req_bus.blue            <= p.blue;
      req_bus.green           <= p.green;
      req_bus.red             <= p.red;
      req_bus.frame_end       <= p.frame_end;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_pixel(p);
   endtask

   task automatic write_register(input roi_tm_pkg::csr_index_type idx, input int value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(value);
      @(posedge clock);
   endtask

   task automatic configure(input int col, input int row, input int thr, input int persist);
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_register(roi_tm_pkg::CSR_WINDOW_COLUMN, col);
      write_register(roi_tm_pkg::CSR_WINDOW_ROW, row);
      write_register(roi_tm_pkg::CSR_MATCH_THRESHOLD, thr);
      write_register(roi_tm_pkg::CSR_PERSIST_FRAMES, persist);
      csr_write   <= 1'b0;
      cfg_col     = col & 'hFFF;
      cfg_row     = row & 'hFFF;
      cfg_thr     = thr & 'h1FF;
      cfg_persist = persist & 'hFFFF;
   endtask

   // frame ending outside the window: all differences zero
   task automatic send_hit();
      send_pixel(video_px(cfg_col == 0 ? COORD_MAX : 0, 0, 8'($urandom), 8'($urandom),
                          8'($urandom), 1'b1));
   endtask

   // full-scale difference at window origin, where every template holds black
   task automatic send_miss();
      send_pixel(video_px(cfg_col, cfg_row, 8'hFF, 8'hFF, 8'hFF, 1'b1));
   endtask

   task automatic send_random_frame();
      int n;
      int tmpl;
      int spread;
      int c;
      int r;
      n    = $urandom_range(1, 6);
      tmpl = $urandom_range(0, TEMPLATES - 1);
      if (cfg_thr > 1 && $urandom_range(0, 9) < 7) spread = $urandom_range(0, (cfg_thr - 1) / 2);
      else spread = $urandom_range(0, 255);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_pixel(tmpl_wr($urandom_range(0, 3), $urandom_range(0, 127),
                               $urandom_range(0, 31), 8'($urandom), 8'($urandom),
                               8'($urandom), 1'($urandom)));
         if ($urandom_range(0, 3) != 0) begin
            send_pixel(window_px(tmpl, spread, i == n - 1));
         end else begin
            do begin
               c = $urandom_range(0, COORD_MAX);
               r = $urandom_range(0, COORD_MAX);
            end while (!readable(c, r));
            send_pixel(video_px(c, r, 8'($urandom), 8'($urandom), 8'($urandom), i == n - 1));
         end
      end
   endtask

   // corners, the origin's neighbour and a few random spots, in every template
   task automatic test_template_load();
      load_dc.push_back(0);         load_dr.push_back(0);
      load_dc.push_back(1);         load_dr.push_back(0);
      load_dc.push_back(WIN_W - 1); load_dr.push_back(0);
      load_dc.push_back(0);         load_dr.push_back(WIN_H - 1);
      load_dc.push_back(WIN_W - 1); load_dr.push_back(WIN_H - 1);
      while (load_dc.size() < LOAD_POINTS) begin
         load_dc.push_back($urandom_range(0, WIN_W - 1));
         load_dr.push_back($urandom_range(0, WIN_H - 1));
      end
      foreach (load_dc[i])
         for (int sel = 0; sel < TEMPLATES; sel++)
            send_pixel(tmpl_wr(sel, load_dc[i], load_dr[i], 8'($urandom), 8'($urandom),
                               8'($urandom), 1'($urandom)));
   endtask

   task automatic test_directed_cases();
      logic [23:0] corner;
      // ignored writes: bad select, outside the template, far corner
      send_pixel(tmpl_wr(3, 0, 0, 8'hFF, 8'hFF, 8'hFF, 1'b0));
      send_pixel(tmpl_wr(0, WIN_W, 0, 8'hFF, 8'hFF, 8'hFF, 1'b0));
      send_pixel(tmpl_wr(1, 0, WIN_H, 8'hFF, 8'hFF, 8'hFF, 1'b0));
      send_pixel(tmpl_wr(2, COORD_MAX, COORD_MAX, 8'hFF, 8'hFF, 8'hFF, 1'b1));
      for (int sel = 0; sel < TEMPLATES; sel++)
         send_pixel(tmpl_wr(sel, 1, 0, 8'd100, 8'd100, 8'd100, 1'b0));
      // one below the threshold, then exactly on it
      send_pixel(video_px(cfg_col + 1, cfg_row, 8'd199, 8'd100, 8'd100, 1'b1));
      send_pixel(video_px(cfg_col + 1, cfg_row, 8'd200, 8'd100, 8'd100, 1'b1));
      // frame_end on a write must not produce a result
      for (int sel = 0; sel < TEMPLATES; sel++)
         send_pixel(tmpl_wr(sel, 0, 0, 8'h00, 8'h00, 8'h00, sel == 1));
      send_miss();
      send_pixel(video_px(COORD_MAX, 0, 8'hFF, 8'hFF, 8'hFF, 1'b1));
      corner = tmpl_mem[(WIN_H - 1) * WIN_W + WIN_W - 1];
      send_pixel(video_px(cfg_col + WIN_W - 1, cfg_row + WIN_H - 1, corner[23:16],
                          corner[15:8], corner[7:0], 1'b0));
      send_pixel(video_px(cfg_col, cfg_row, 8'h00, 8'h00, 8'h00, 1'b1));
      // just outside each edge
      send_pixel(video_px(cfg_col - 1, cfg_row, 8'hFF, 8'hFF, 8'hFF, 1'b0));
      send_pixel(video_px(cfg_col + WIN_W, cfg_row + WIN_H, 8'hFF, 8'hFF, 8'hFF, 1'b1));
      send_pixel(video_px(cfg_col, cfg_row - 1, 8'hFF, 8'hFF, 8'hFF, 1'b1));
   endtask

   task automatic test_persistence_run();
      configure(0, 0, 100, 3);
      repeat (5) send_hit();
      send_miss();
      repeat (4) send_hit();
      configure(0, 0, 100, 1);
      send_miss();
      repeat (3) send_hit();
      configure(0, 0, 100, 0);
      repeat (3) send_hit();
      send_miss();
      repeat (2) send_hit();
   endtask

   task automatic test_threshold_extremes();
      configure(98, 975, 0, 2);
      repeat (3) send_hit();
      send_miss();
      configure(98, 975, 256, 2);
      repeat (3) send_miss();
      send_hit();
   endtask

   task automatic test_window_extremes();
      configure(COORD_MAX, COORD_MAX, 100, 2);
      send_pixel(video_px(COORD_MAX, COORD_MAX, 8'h00, 8'h00, 8'h00, 1'b1));
      send_miss();
      send_pixel(video_px(COORD_MAX - 1, COORD_MAX, 8'hFF, 8'hFF, 8'hFF, 1'b1));
      repeat (4) send_random_frame();
      configure(0, COORD_MAX, 100, 2);
      repeat (4) send_random_frame();
      configure(COORD_MAX, 0, 100, 2);
      repeat (4) send_random_frame();
      configure(0, 0, 100, 2);
      repeat (4) send_random_frame();
   endtask

   // sink holds off while frames keep coming, so the core must stall its input
   task automatic test_output_backpressure();
      configure(98, 975, 100, 4);
      sender_gaps_on   = 1'b0;
      hold_off_request = 1'b1;
      repeat (40) send_hit();
      sender_gaps_on = 1'b1;
      repeat (5) send_random_frame();
   endtask

   task automatic test_random_traffic();
      int start;
      int col;
      int row;
      int thr;
      int persist;
      start = live_items;
      while (live_items - start < RANDOM_ITEMS) begin
         case ($urandom_range(0, 3))
            0:       col = 0;
            1:       col = COORD_MAX;
            default: col = $urandom_range(0, COORD_MAX);
         endcase
         case ($urandom_range(0, 3))
            0:       row = 0;
            1:       row = COORD_MAX;
            default: row = $urandom_range(0, COORD_MAX);
         endcase
         case ($urandom_range(0, 5))
            0:       thr = 0;
            1:       thr = 256;
            default: thr = $urandom_range(1, 255);
         endcase
         case ($urandom_range(0, 5))
            0:       persist = 0;
            1:       persist = 1;
            2:       persist = 65535;
            default: persist = $urandom_range(2, 8);
         endcase
         configure(col, row, thr, persist);
         repeat ($urandom_range(6, 14)) send_random_frame();
      end
   endtask

   task automatic test_quiet_tail();
      sender_gaps_on = 1'b0;
      sink_stalls_on = 1'b0;
      configure(98, 975, 100, 3);
      repeat (20) send_random_frame();
   endtask

   initial begin
      reset                   <= 1'b1;
      csr_write               <= 1'b0;
      csr_index               <= roi_tm_pkg::CSR_WINDOW_COLUMN;
      csr_data                <= '0;
      req_bus.valid           <= 1'b0;
      req_bus.opcode          <= roi_tm_pkg::OP_TEMPLATE_WRITE;
      req_bus.template_select <= '0;
      req_bus.column          <= '0;
      req_bus.row             <= '0;
      req_bus.blue            <= '0;
      req_bus.green           <= '0;
      req_bus.red             <= '0;
      req_bus.frame_end       <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_template_load();
      test_directed_cases();
      test_persistence_run();
      test_threshold_extremes();
      test_window_extremes();
      test_output_backpressure();
      test_random_traffic();
      test_quiet_tail();

      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
